@@ rtl/core/bc_pkg.sv @@
package bc_pkg;

  // width of the input fields
  localparam int unsigned FieldBits = 8;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture n and k, set up the first partial value
    logic mul;       // multiply the partial value by the next factor
    logic div_step;  // one bit of the exact division by the step index
    logic commit;    // take the quotient as the new partial value
    logic sat;       // saturate and flag overflow
    logic emit;      // move the result into the output register
  } bc_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic steps_done;  // step index has passed the pick count
    logic div_last;    // last bit of the division this cycle
    logic quot_ovf;    // quotient does not fit the result width
    logic out_free;    // output register can take a new item
  } bc_sts_t;

endpackage

@@ rtl/core/bc_if.sv @@
// input channel: set size and pick count
interface bc_in_if;
  logic                              valid;
  logic                              ready;
  logic [bc_pkg::FieldBits-1:0]      set_size;
  logic [bc_pkg::FieldBits-1:0]      pick_count;

  modport source (output valid, output set_size, output pick_count, input ready);
  modport sink   (input valid, input set_size, input pick_count, output ready);
endinterface

// output channel: coefficient and overflow flag
interface bc_out_if #(
  parameter int unsigned RESULT_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic [RESULT_BITS-1:0] coefficient;
  logic                   overflow;

  modport source (output valid, output coefficient, output overflow, input ready);
  modport sink   (input valid, input coefficient, input overflow, output ready);
endinterface

@@ rtl/core/bc_ctrl.sv @@
module bc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bc_pkg::bc_sts_t sts_i,
  output bc_pkg::bc_cmd_t cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StCheck  = 3'd1;
  localparam logic [2:0] StMul    = 3'd2;
  localparam logic [2:0] StDiv    = 3'd3;
  localparam logic [2:0] StCommit = 3'd4;
  localparam logic [2:0] StDone   = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        state_d = sts_i.steps_done ? StDone : StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        if (sts_i.quot_ovf) begin
          cmd_o.sat = 1'b1;
          state_d   = StDone;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = StCheck;
        end
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/bc_dp.sv @@
module bc_dp #(
  parameter int unsigned RESULT_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bc_pkg::FieldBits-1:0] set_size_i,
  input  logic [bc_pkg::FieldBits-1:0] pick_count_i,
  input  bc_pkg::bc_cmd_t              cmd_i,
  output bc_pkg::bc_sts_t              sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [RESULT_BITS-1:0]       coefficient_o,
  output logic                         overflow_o
);

  localparam int unsigned FB  = bc_pkg::FieldBits;
  localparam int unsigned PW  = RESULT_BITS + FB;
  localparam int unsigned CW  = $clog2(PW);

  logic [FB-1:0]          n_q, k_q, i_q;
  logic [RESULT_BITS-1:0] acc_q;
  logic                   ovf_q;
  logic [PW-1:0]          div_q;
  logic [FB-2:0]          rem_q;
  logic [CW-1:0]          cnt_q;
  logic                   out_valid_q;
  logic [RESULT_BITS-1:0] coef_q;
  logic                   oflag_q;

  // symmetry swap and special cases at load
  logic              k_gt_n;
  logic [FB-1:0]     k_eff;
  logic [RESULT_BITS-1:0] acc_init;
  always_comb begin
    k_gt_n = (pick_count_i > set_size_i);
    if (k_gt_n) begin
      k_eff = '0;
    end else if ({pick_count_i, 1'b0} > {1'b0, set_size_i}) begin
      k_eff = set_size_i - pick_count_i;
    end else begin
      k_eff = pick_count_i;
    end
    if (k_gt_n) begin
      acc_init = '0;
    end else if (k_eff == '0) begin
      acc_init = RESULT_BITS'(1);
    end else begin
      acc_init = RESULT_BITS'(set_size_i);
    end
  end

  // next factor n - i + 1
  logic [FB-1:0] factor;
  assign factor = n_q - i_q + FB'(1);

  // one restoring division bit
  logic [FB-1:0] r_shift;
  logic          q_bit;
  logic [FB-1:0] r_sub;
  assign r_shift = {rem_q, div_q[PW-1]};
  assign q_bit   = (r_shift >= i_q);
  assign r_sub   = r_shift - i_q;

  // status to the controller
  assign sts_o.steps_done = (i_q > k_q);
  assign sts_o.div_last   = (cnt_q == CW'(PW - 1));
  assign sts_o.quot_ovf   = (div_q[PW-1:RESULT_BITS] != '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q   <= set_size_i;
      k_q   <= k_eff;
      i_q   <= FB'(2);
      acc_q <= acc_init;
      ovf_q <= 1'b0;
    end
    if (cmd_i.mul) begin
      div_q <= PW'(acc_q) * PW'(factor);
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      div_q <= {div_q[PW-2:0], q_bit};
      rem_q <= q_bit ? r_sub[FB-2:0] : r_shift[FB-2:0];
      cnt_q <= cnt_q + CW'(1);
    end
    if (cmd_i.commit) begin
      acc_q <= div_q[RESULT_BITS-1:0];
      i_q   <= i_q + FB'(1);
    end
    if (cmd_i.sat) begin
      acc_q <= '1;
      ovf_q <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      coef_q  <= acc_q;
      oflag_q <= ovf_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = coef_q;
  assign overflow_o    = oflag_q;

endmodule

@@ rtl/core/binomial_coefficient.sv @@
// from item accepted to result valid the controller runs s = min(k, n-k) - 1 loop steps,
//   fewer when the value saturates early
//   (0 when k > n or min(k, n-k) <= 1); the result may then wait for the output register
// each step is a check, a multiply, a bit-serial division of a RESULT_BITS+8 bit product and a commit
// throughput: one item at a time; the next item is taken once the result is registered
// reset: asynchronous active low, clears controller state and output valid
module binomial_coefficient #(
  parameter int unsigned RESULT_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bc_in_if.sink     req_i,
  bc_out_if.source  rsp_o
);

  bc_pkg::bc_cmd_t cmd;
  bc_pkg::bc_sts_t sts;
  logic            in_ready;

  // sequencer
  bc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // multiply, divide and output register
  bc_dp #(
    .RESULT_BITS (RESULT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .set_size_i    (req_i.set_size),
    .pick_count_i  (req_i.pick_count),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .coefficient_o (rsp_o.coefficient),
    .overflow_o    (rsp_o.overflow)
  );

  assign req_i.ready = in_ready;

endmodule
